/* src/ccpp_pkg.sv */
// Package: shared types, tag and kind codes, and tag class helpers for the constant pool parser.
package ccpp_pkg;

  typedef enum logic [7:0] {
    PH_COUNT_HI = 8'b0000_0001,
    PH_COUNT_LO = 8'b0000_0010,
    PH_TAG      = 8'b0000_0100,
    PH_LEN_HI   = 8'b0000_1000,
    PH_LEN_LO   = 8'b0001_0000,
    PH_TEXT     = 8'b0010_0000,
    PH_PAYLOAD  = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  localparam logic [3:0] KIND_TEXT_HDR  = 4'd0;
  localparam logic [3:0] KIND_TEXT_BYTE = 4'd1;
  localparam logic [3:0] KIND_INT       = 4'd2;
  localparam logic [3:0] KIND_FLOAT     = 4'd3;
  localparam logic [3:0] KIND_LONG      = 4'd4;
  localparam logic [3:0] KIND_DOUBLE    = 4'd5;
  localparam logic [3:0] KIND_ONE_REF   = 4'd6;
  localparam logic [3:0] KIND_TWO_REF   = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd8;
  localparam logic [3:0] KIND_EMPTY     = 4'd9;

  localparam logic [7:0] TAG_UTF8        = 8'd1;
  localparam logic [7:0] TAG_INT         = 8'd3;
  localparam logic [7:0] TAG_FLOAT       = 8'd4;
  localparam logic [7:0] TAG_LONG        = 8'd5;
  localparam logic [7:0] TAG_DOUBLE      = 8'd6;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_STRING      = 8'd8;
  localparam logic [7:0] TAG_FIELD       = 8'd9;
  localparam logic [7:0] TAG_METHOD      = 8'd10;
  localparam logic [7:0] TAG_IMETHOD     = 8'd11;
  localparam logic [7:0] TAG_NAME_TYPE   = 8'd12;
  localparam logic [7:0] TAG_METHOD_TYPE = 8'd16;
  localparam logic [7:0] TAG_INVOKE_DYN  = 8'd18;
  localparam logic [7:0] TAG_MODULE      = 8'd19;
  localparam logic [7:0] TAG_PACKAGE     = 8'd20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_pool;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] entry_index;
    logic [3:0]  entry_kind;
    logic [7:0]  entry_tag;
    logic [63:0] raw_value;
    logic [15:0] first_ref;
    logic [15:0] second_ref;
    logic        last_of_string;
    logic        last_of_pool;
  } result_t;

  function automatic logic is_wide(input logic [7:0] tag);
    return (tag inside {TAG_LONG, TAG_DOUBLE});
  endfunction

  function automatic logic is_value(input logic [7:0] tag);
    return (tag inside {TAG_INT, TAG_FLOAT, TAG_LONG, TAG_DOUBLE});
  endfunction

  function automatic logic is_one_ref(input logic [7:0] tag);
    return (tag inside {TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE, TAG_MODULE, TAG_PACKAGE});
  endfunction

  function automatic logic is_two_ref(input logic [7:0] tag);
    return (tag inside {TAG_FIELD, TAG_METHOD, TAG_IMETHOD, TAG_NAME_TYPE, TAG_INVOKE_DYN});
  endfunction

endpackage

/* src/ccpp_in_stage.sv */
// Input register stage: holds one incoming byte beat for the parser.
module ccpp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccpp_pkg::in_beat_t in_beat,
  output logic               q_valid,
  input  logic               q_ready,
  output ccpp_pkg::in_beat_t q_beat
);

  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_beat <= in_beat;
    end
  end

endmodule

/* src/ccpp_parser.sv */
// Parser: pool state, per-byte decode, and the result register.
module ccpp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccpp_pkg::in_beat_t in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output ccpp_pkg::result_t  result
);

  ccpp_pkg::phase_t phase, phase_next, cur_phase;
  logic [15:0] pool_count, pool_count_next;
  logic [15:0] slot_index, slot_index_next;
  logic [7:0]  current_tag, current_tag_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [63:0] value_accumulator, value_accumulator_next;
  logic [15:0] held_first_ref, held_first_ref_next;

  ccpp_pkg::result_t res;
  logic        take;
  logic        emit;
  logic        do_adv;
  logic [7:0]  b;
  logic [7:0]  adv_tag;
  logic [16:0] adv_sum;
  logic        adv_done;
  logic [63:0] acc_shift;
  logic [15:0] bytes_dec;
  logic [15:0] count_lo;
  logic [15:0] len_lo;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign b        = in_beat.data_byte;

  always_comb begin
    cur_phase = in_beat.start_of_pool ? ccpp_pkg::PH_COUNT_HI : phase;
    adv_tag   = (cur_phase == ccpp_pkg::PH_TAG) ? b : current_tag;
    adv_sum   = {1'b0, slot_index} + (ccpp_pkg::is_wide(adv_tag) ? 17'd2 : 17'd1);
    adv_done  = (adv_sum >= {1'b0, pool_count});
    acc_shift = {value_accumulator[55:0], b};
    bytes_dec = bytes_left - 16'd1;
    count_lo  = {pool_count[15:8], b};
    len_lo    = {bytes_left[15:8], b};

    phase_next             = cur_phase;
    pool_count_next        = pool_count;
    slot_index_next        = slot_index;
    current_tag_next       = current_tag;
    bytes_left_next        = bytes_left;
    value_accumulator_next = value_accumulator;
    held_first_ref_next    = held_first_ref;
    emit                   = 1'b0;
    do_adv                 = 1'b0;

    res             = '0;
    res.entry_index = slot_index;
    res.entry_tag   = current_tag;

    case (cur_phase)
      ccpp_pkg::PH_COUNT_HI: begin
        pool_count_next        = {b, 8'h00};
        slot_index_next        = 16'd1;
        current_tag_next       = 8'd0;
        bytes_left_next        = 16'd0;
        value_accumulator_next = 64'd0;
        held_first_ref_next    = 16'd0;
        phase_next             = ccpp_pkg::PH_COUNT_LO;
      end
      ccpp_pkg::PH_COUNT_LO: begin
        pool_count_next = count_lo;
        slot_index_next = 16'd1;
        if (count_lo <= 16'd1) begin
          phase_next       = ccpp_pkg::PH_DONE;
          current_tag_next = 8'd0;
          emit             = 1'b1;
          res.entry_index  = 16'd0;
          res.entry_tag    = 8'd0;
          res.entry_kind   = ccpp_pkg::KIND_EMPTY;
          res.last_of_pool = 1'b1;
        end else begin
          phase_next = ccpp_pkg::PH_TAG;
        end
      end
      ccpp_pkg::PH_TAG: begin
        current_tag_next       = b;
        value_accumulator_next = 64'd0;
        held_first_ref_next    = 16'd0;
        res.entry_tag          = b;
        if (b == ccpp_pkg::TAG_UTF8) begin
          phase_next = ccpp_pkg::PH_LEN_HI;
        end else if (ccpp_pkg::is_wide(b)) begin
          bytes_left_next = 16'd8;
          phase_next      = ccpp_pkg::PH_PAYLOAD;
        end else if (ccpp_pkg::is_value(b) || ccpp_pkg::is_two_ref(b)) begin
          bytes_left_next = 16'd4;
          phase_next      = ccpp_pkg::PH_PAYLOAD;
        end else if (ccpp_pkg::is_one_ref(b)) begin
          bytes_left_next = 16'd2;
          phase_next      = ccpp_pkg::PH_PAYLOAD;
        end else begin
          emit             = 1'b1;
          do_adv           = 1'b1;
          res.entry_kind   = ccpp_pkg::KIND_UNKNOWN;
          res.last_of_pool = adv_done;
        end
      end
      ccpp_pkg::PH_LEN_HI: begin
        bytes_left_next = {b, 8'h00};
        phase_next      = ccpp_pkg::PH_LEN_LO;
      end
      ccpp_pkg::PH_LEN_LO: begin
        bytes_left_next = len_lo;
        emit            = 1'b1;
        res.entry_kind  = ccpp_pkg::KIND_TEXT_HDR;
        if (len_lo == 16'd0) begin
          do_adv             = 1'b1;
          res.last_of_string = 1'b1;
          res.last_of_pool   = adv_done;
        end else begin
          res.raw_value = {48'd0, len_lo};
          phase_next    = ccpp_pkg::PH_TEXT;
        end
      end
      ccpp_pkg::PH_TEXT: begin
        bytes_left_next = bytes_dec;
        emit            = 1'b1;
        res.entry_kind  = ccpp_pkg::KIND_TEXT_BYTE;
        res.raw_value   = {56'd0, b};
        if (bytes_dec == 16'd0) begin
          do_adv             = 1'b1;
          res.last_of_string = 1'b1;
          res.last_of_pool   = adv_done;
        end
      end
      ccpp_pkg::PH_PAYLOAD: begin
        value_accumulator_next = acc_shift;
        bytes_left_next        = bytes_dec;
        if (bytes_dec == 16'd2 && !ccpp_pkg::is_value(current_tag)) begin
          held_first_ref_next = acc_shift[15:0];
        end
        if (bytes_dec == 16'd0) begin
          emit             = 1'b1;
          do_adv           = 1'b1;
          res.last_of_pool = adv_done;
          if (current_tag == ccpp_pkg::TAG_INT) begin
            res.entry_kind = ccpp_pkg::KIND_INT;
            res.raw_value  = {32'd0, acc_shift[31:0]};
          end else if (current_tag == ccpp_pkg::TAG_FLOAT) begin
            res.entry_kind = ccpp_pkg::KIND_FLOAT;
            res.raw_value  = {32'd0, acc_shift[31:0]};
          end else if (current_tag == ccpp_pkg::TAG_LONG) begin
            res.entry_kind = ccpp_pkg::KIND_LONG;
            res.raw_value  = acc_shift;
          end else if (current_tag == ccpp_pkg::TAG_DOUBLE) begin
            res.entry_kind = ccpp_pkg::KIND_DOUBLE;
            res.raw_value  = acc_shift;
          end else if (ccpp_pkg::is_one_ref(current_tag)) begin
            res.entry_kind = ccpp_pkg::KIND_ONE_REF;
            res.raw_value  = {48'd0, acc_shift[15:0]};
            res.first_ref  = acc_shift[15:0];
          end else begin
            res.entry_kind = ccpp_pkg::KIND_TWO_REF;
            res.raw_value  = {32'd0, acc_shift[31:0]};
            res.first_ref  = held_first_ref;
            res.second_ref = acc_shift[15:0];
          end
        end
      end
      default: begin
      end
    endcase

    if (do_adv) begin
      if (adv_done) begin
        phase_next = ccpp_pkg::PH_DONE;
      end else begin
        slot_index_next = adv_sum[15:0];
        phase_next      = ccpp_pkg::PH_TAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ccpp_pkg::PH_COUNT_HI;
      pool_count        <= 16'd0;
      slot_index        <= 16'd1;
      current_tag       <= 8'd0;
      bytes_left        <= 16'd0;
      value_accumulator <= 64'd0;
      held_first_ref    <= 16'd0;
      out_valid         <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      pool_count        <= pool_count_next;
      slot_index        <= slot_index_next;
      current_tag       <= current_tag_next;
      bytes_left        <= bytes_left_next;
      value_accumulator <= value_accumulator_next;
      held_first_ref    <= held_first_ref_next;
      out_valid         <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= res;
    end
  end

endmodule

/* src/class_constant_pool_parser.sv */
// Top level: byte-serial class-file constant pool parser.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | data_byte, start_of_pool
//  out     | out_valid / out_ready| entry_index, entry_kind, entry_tag, raw_value,
//          |                      | first_ref, second_ref, last_of_string, last_of_pool
//
// One byte beat per cycle sustained while results are not stalled; a byte is taken into the
// input register, then decoded into the result register, where its result becomes valid.
// Each byte only loads a field, shifts the value register or steps a 16-bit counter.
// rst is synchronous and returns the parser to waiting for the count high byte.
// A stalled result holds in the result register; one more byte waits in the input register.
module class_constant_pool_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_pool,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] entry_index,
  output logic [3:0]  entry_kind,
  output logic [7:0]  entry_tag,
  output logic [63:0] raw_value,
  output logic [15:0] first_ref,
  output logic [15:0] second_ref,
  output logic        last_of_string,
  output logic        last_of_pool
);

  ccpp_pkg::in_beat_t in_beat;
  ccpp_pkg::in_beat_t q_beat;
  ccpp_pkg::result_t  result;
  logic q_valid;
  logic q_ready;

  assign in_beat.data_byte     = data_byte;
  assign in_beat.start_of_pool = start_of_pool;

  ccpp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_beat   (q_beat)
  );

  ccpp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_beat   (q_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign entry_index    = result.entry_index;
  assign entry_kind     = result.entry_kind;
  assign entry_tag      = result.entry_tag;
  assign raw_value      = result.raw_value;
  assign first_ref      = result.first_ref;
  assign second_ref     = result.second_ref;
  assign last_of_string = result.last_of_string;
  assign last_of_pool   = result.last_of_pool;

  a_string_end_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_string |->
      (entry_kind == ccpp_pkg::KIND_TEXT_HDR || entry_kind == ccpp_pkg::KIND_TEXT_BYTE))
    else $error("last_of_string on a non-text result");

  a_empty_pool: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_kind == ccpp_pkg::KIND_EMPTY |->
      last_of_pool && entry_index == 16'd0 && entry_tag == 8'd0)
    else $error("empty-pool result malformed");

  a_one_ref: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_kind == ccpp_pkg::KIND_ONE_REF |->
      second_ref == 16'd0 && raw_value == {48'd0, first_ref})
    else $error("one-ref result fields disagree");

  a_stage_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_ready)
    else $error("parser took a byte while the result was stalled");

endmodule
